@@ rtl/iie_pkg.sv @@
// ----------------------------------------------------------------------------
// iie_pkg: shared types and constants for the indexed insert/erase list
// Beat structs, action and status codes, and the per-cycle shift command
// that the control block hands to the row of storage cells.
// ----------------------------------------------------------------------------
package iie_pkg;

  // Action codes carried in the input beat.
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_ERASE  = 2'd1,
    ACT_READ   = 2'd2
  } act_e;

  // Status codes reported with every result beat.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef logic signed [31:0] word_t;

  // Value returned by a read at an index past the end of the list.
  localparam word_t FailWord = 32'sh8000_0000;

  // Number of cell taps combined in one first-level group of the read tree.
  localparam int GroupSize = 32;

  // Input beat.
  typedef struct packed {
    logic [1:0] action;
    logic [5:0] position;
    word_t      value;
  } in_item_t;

  // Result beat.
  typedef struct packed {
    word_t      read_value;
    logic [1:0] status;
    logic [6:0] count;
    logic       is_empty;
  } out_item_t;

  // Shift command broadcast along the row of cells.
  typedef struct packed {
    logic insert;
    logic erase;
    logic read;
  } cmd_t;

endpackage

@@ rtl/indexed_insert_erase_list.sv @@
// ----------------------------------------------------------------------------
// indexed_insert_erase_list: ordered list with insert/erase/read at an index
// Top level: a row of DEPTH storage cells, the control block, a grouped
// read tree and the result register.
// ----------------------------------------------------------------------------
// The list lives in a row of DEPTH cells; an insert or erase shifts the
// cells from the index upward by one place in the cycle the beat is accepted,
// so a new input beat can be taken every cycle while the output does not stall,
// and the sustained rate is then one item per cycle. Each result passes a first
// stage, which combines the cell read taps in groups of 32 into registers, and
// then the result register, which takes the OR of the groups. The input side
// only stalls when both of those stages hold a beat that the output cannot
// take. The storage needs no clearing pass after reset; only the element
// count and the stage valid flags are reset.
module indexed_insert_erase_list
  import iie_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int CmpW = (CntW > 7) ? CntW : 7;
  localparam int NGrp = (DEPTH + GroupSize - 1) / GroupSize;

  cmd_t            cmd;
  logic [CmpW-1:0] pos;
  status_e         status;
  logic            fail_read;
  logic [CntW-1:0] count_after;
  logic            in_acc;
  logic            s1_adv;

  word_t cell_word [DEPTH];
  word_t cell_tap  [DEPTH];
  word_t grp_or    [NGrp];

  // First stage registers.
  logic            s1_valid_q, s1_valid_d;
  word_t           grp_q [NGrp];
  status_e         s1_status_q;
  logic [6:0]      s1_count_q;
  logic            s1_empty_q;
  logic            s1_fail_q;

  // Result register.
  logic            out_valid_q, out_valid_d;
  out_item_t       out_item_q;
  word_t           read_or;

  // Handshake: the first stage moves on whenever the result register is free or its beat is taken.
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  iie_ctrl #(
    .DEPTH (DEPTH),
    .CNT_W (CntW),
    .CMP_W (CmpW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .item_i      (in_item_i),
    .cmd_o       (cmd),
    .pos_o       (pos),
    .status_o    (status),
    .fail_read_o (fail_read),
    .count_o     (count_after)
  );

  // Row of cells, each wired to its neighbours; the first sees zero below and the last its own word above.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t lower;
    word_t upper;
    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_word[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign upper = cell_word[i];
    end else begin : g_mid_hi
      assign upper = cell_word[i+1];
    end
    iie_cell #(
      .IDX   (i),
      .CMP_W (CmpW)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .pos_i   (pos),
      .value_i (in_item_i.value),
      .lower_i (lower),
      .upper_i (upper),
      .word_o  (cell_word[i]),
      .tap_o   (cell_tap[i])
    );
  end

  // First level of the read tree: OR the taps of each group of cells.
  for (genvar g = 0; g < NGrp; g++) begin : g_grp
    always_comb begin
      grp_or[g] = '0;
      for (int k = 0; k < GroupSize; k++) begin
        if (g * GroupSize + k < DEPTH) begin
          grp_or[g] = grp_or[g] | cell_tap[g * GroupSize + k];
        end
      end
    end
  end

  // Second level: OR the registered group results.
  always_comb begin
    read_or = '0;
    for (int g = 0; g < NGrp; g++) begin
      read_or = read_or | grp_q[g];
    end
  end

  assign s1_valid_d  = in_acc || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_adv || (out_valid_q && out_stall_i);

  // Control state of the two stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // First stage payload, captured with the accepted beat.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int g = 0; g < NGrp; g++) begin
        grp_q[g] <= grp_or[g];
      end
      s1_status_q <= status;
      s1_count_q  <= 7'(count_after);
      s1_empty_q  <= (count_after == '0);
      s1_fail_q   <= fail_read;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_item_q.read_value <= s1_fail_q ? FailWord : read_or;
      out_item_q.status     <= s1_status_q;
      out_item_q.count      <= s1_count_q;
      out_item_q.is_empty   <= s1_empty_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i && s1_valid_q) |-> in_stall_o)
    else $error("input taken while both stages were blocked");

  a_s1_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !out_valid_q && !in_valid_i) |=> out_valid_q && !s1_valid_q)
    else $error("first stage beat did not move to the result register");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q)
    else $error("stalled result beat was dropped");
`endif

endmodule

@@ rtl/iie_cell.sv @@
// ----------------------------------------------------------------------------
// iie_cell: one storage cell of the list
// Holds a single entry. On insert it takes its lower neighbour's word if above the
// insert index (the new value at it); on erase at or above the index, its upper neighbour's.
// It drives its word onto a read tap when the read index matches its own.
// ----------------------------------------------------------------------------
module iie_cell
  import iie_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CMP_W = 7
) (
  input  logic             clk_i,
  input  cmd_t             cmd_i,
  input  logic [CMP_W-1:0] pos_i,
  input  word_t            value_i,
  input  word_t            lower_i,
  input  word_t            upper_i,
  output word_t            word_o,
  output word_t            tap_o
);

  localparam logic [CMP_W-1:0] MyIdx = CMP_W'(IDX);

  word_t word_q;
  word_t word_d;

  // Choose the next word from the shift command and this cell's index.
  always_comb begin
    word_d = word_q;
    if (cmd_i.insert) begin
      if (MyIdx == pos_i) begin
        word_d = value_i;
      end else if (MyIdx > pos_i) begin
        word_d = lower_i;
      end
    end else if (cmd_i.erase) begin
      if (MyIdx >= pos_i) begin
        word_d = upper_i;
      end
    end
  end

  // Entry storage needs no reset; unwritten cells are never read.
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  // Read tap: zero unless this cell is the one addressed.
  assign tap_o  = (cmd_i.read && (MyIdx == pos_i)) ? word_q : '0;
  assign word_o = word_q;

endmodule

@@ rtl/iie_ctrl.sv @@
// ----------------------------------------------------------------------------
// iie_ctrl: list control and element count
// Decodes each accepted beat against the current count, decides the status,
// issues the shift command to the cells and keeps the element count.
// ----------------------------------------------------------------------------
module iie_ctrl
  import iie_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int CNT_W = 7,
  parameter int CMP_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  in_item_t         item_i,
  output cmd_t             cmd_o,
  output logic [CMP_W-1:0] pos_o,
  output status_e          status_o,
  output logic             fail_read_o,
  output logic [CNT_W-1:0] count_o
);

  localparam logic [CNT_W-1:0] Full = CNT_W'(DEPTH);

  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] count_d;
  logic [CMP_W-1:0] count_w;
  cmd_t             cmd;

  assign pos_o   = CMP_W'(item_i.position);
  assign count_w = CMP_W'(count_q);

  // Decode the action and check the index against the current count.
  always_comb begin
    cmd         = '0;
    status_o    = ST_OK;
    fail_read_o = 1'b0;
    unique case (act_e'(item_i.action))
      ACT_INSERT: begin
        if (count_q == Full) begin
          status_o = ST_FULL;
        end else if (pos_o > count_w) begin
          status_o = ST_RANGE;
        end else begin
          cmd.insert = 1'b1;
        end
      end
      ACT_ERASE: begin
        if (pos_o >= count_w) begin
          status_o = ST_RANGE;
        end else begin
          cmd.erase = 1'b1;
        end
      end
      ACT_READ: begin
        if (pos_o >= count_w) begin
          status_o    = ST_RANGE;
          fail_read_o = 1'b1;
        end else begin
          cmd.read = 1'b1;
        end
      end
      default: begin
        // Unused code: no change, status ok.
        cmd = '0;
      end
    endcase
  end

  assign cmd_o = accept_i ? cmd : '0;

  // Element count follows successful inserts and erases.
  always_comb begin
    count_d = count_q;
    if (cmd_o.insert) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_o.erase) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_d;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Full)
    else $error("element count exceeds capacity");

  a_count_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept_i |=> $stable(count_q))
    else $error("element count changed without an accepted beat");

  a_count_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.insert |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not grow the list by one");
`endif

endmodule
